[hdl/cmae_pkg.sv]
// Shared constants, command/status types and reciprocal table for the moving average.
package cmae_pkg;

   localparam int HALF_WINDOW = 5;
   localparam int SAMPLE_BITS = 16;
   localparam int WIN_DEPTH   = 2 * HALF_WINDOW + 1;
   localparam int SEEN_BITS   = $clog2(WIN_DEPTH + 1);
   localparam int BACK_BITS   = $clog2(HALF_WINDOW + 1);
   localparam int DIV_BITS    = $clog2(2 * HALF_WINDOW + 1);
   localparam int SUM_BITS    = SAMPLE_BITS + $clog2(2 * HALF_WINDOW);
   localparam int RECIP_SHIFT = 24;
   localparam int RECIP_BITS  = RECIP_SHIFT + 1;
   localparam int PROD_BITS   = SUM_BITS + RECIP_BITS;

   typedef struct packed {
      logic                 shift;
      logic                 load_sum;
      logic                 load_prod;
      logic                 load_out;
      logic                 last;
      logic [BACK_BITS-1:0] back;
      logic [SEEN_BITS-1:0] avail;
   } cmd_type;

   typedef struct packed {
      logic out_free;
   } status_type;

   function automatic logic [RECIP_BITS-1:0] recip(input logic [DIV_BITS-1:0] d);
      logic [RECIP_BITS-1:0] r;
      case (d)
         4'd1:    r = 25'd16777216;
         4'd2:    r = 25'd8388608;
         4'd3:    r = 25'd5592406;
         4'd4:    r = 25'd4194304;
         4'd5:    r = 25'd3355444;
         4'd6:    r = 25'd2796203;
         4'd7:    r = 25'd2396746;
         4'd8:    r = 25'd2097152;
         4'd9:    r = 25'd1864136;
         4'd10:   r = 25'd1677722;
         default: r = '0;
      endcase
      return r;
   endfunction

endpackage

[hdl/cmae_ctrl.sv]
// Controller: frame position tracking and result sequencing.
module cmae_ctrl (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_tvalid,
   input  logic                req_tlast,
   output logic                req_tready,
   input  cmae_pkg::status_type status,
   output cmae_pkg::cmd_type    cmd
);

   typedef enum logic [1:0] {ST_IDLE, ST_SUM, ST_MUL, ST_PUT} state_type;

   state_type                          state_ff, state_in;
   logic [cmae_pkg::SEEN_BITS-1:0]     seen_ff, seen_in;
   logic [cmae_pkg::SEEN_BITS-1:0]     avail_ff, avail_in;
   logic [cmae_pkg::BACK_BITS-1:0]     back_ff, back_in;
   logic                               flush_ff, flush_in;
   logic [cmae_pkg::SEEN_BITS-1:0]     seen_new;
   logic [cmae_pkg::SEEN_BITS-1:0]     first;

   localparam logic [cmae_pkg::SEEN_BITS-1:0] DEPTH_S =
      cmae_pkg::SEEN_BITS'(cmae_pkg::WIN_DEPTH);
   localparam logic [cmae_pkg::SEEN_BITS-1:0] HALF_S =
      cmae_pkg::SEEN_BITS'(cmae_pkg::HALF_WINDOW);

   always_comb begin
      state_in   = state_ff;
      seen_in    = seen_ff;
      avail_in   = avail_ff;
      back_in    = back_ff;
      flush_in   = flush_ff;
      req_tready = 1'b0;
      cmd        = '0;
      cmd.back   = back_ff;
      cmd.avail  = avail_ff;
      seen_new   = (seen_ff < DEPTH_S) ? seen_ff + 1'b1 : seen_ff;
      first      = seen_new - 1'b1;
      case (state_ff)
         ST_IDLE: begin
            req_tready = 1'b1;
            if (req_tvalid) begin
               cmd.shift = 1'b1;
               avail_in  = seen_new;
               if (req_tlast) begin
                  flush_in = 1'b1;
                  seen_in  = '0;
                  back_in  = (first > HALF_S) ? cmae_pkg::BACK_BITS'(cmae_pkg::HALF_WINDOW)
                                              : first[cmae_pkg::BACK_BITS-1:0];
                  state_in = ST_SUM;
               end else begin
                  flush_in = 1'b0;
                  seen_in  = seen_new;
                  back_in  = cmae_pkg::BACK_BITS'(cmae_pkg::HALF_WINDOW);
                  if (seen_new > HALF_S) begin
                     state_in = ST_SUM;
                  end
               end
            end
         end
         ST_SUM: begin
            cmd.load_sum = 1'b1;
            state_in     = ST_MUL;
         end
         ST_MUL: begin
            cmd.load_prod = 1'b1;
            state_in      = ST_PUT;
         end
         ST_PUT: begin
            if (status.out_free) begin
               cmd.load_out = 1'b1;
               cmd.last     = flush_ff && (back_ff == '0);
               if (flush_ff && (back_ff != '0)) begin
                  back_in  = back_ff - 1'b1;
                  state_in = ST_SUM;
               end else begin
                  state_in = ST_IDLE;
               end
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         seen_ff  <= '0;
         avail_ff <= '0;
         back_ff  <= '0;
         flush_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         seen_ff  <= seen_in;
         avail_ff <= avail_in;
         back_ff  <= back_in;
         flush_ff <= flush_in;
      end
   end

endmodule

[hdl/cmae_dpath.sv]
// Datapath: sample window, masked neighbour sum, reciprocal divide and result register.
module cmae_dpath (
   input  logic                                clock,
   input  logic                                reset,
   input  logic [cmae_pkg::SAMPLE_BITS-1:0]    sample,
   input  cmae_pkg::cmd_type                   cmd,
   output cmae_pkg::status_type                status,
   output logic [cmae_pkg::SAMPLE_BITS-1:0]    average,
   output logic                                last_result,
   output logic                                no_neighbours,
   output logic                                out_valid,
   input  logic                                out_ready
);

   localparam int PAD = 12;

   logic [cmae_pkg::SAMPLE_BITS-1:0] win_ff [cmae_pkg::WIN_DEPTH];
   logic [cmae_pkg::SUM_BITS-1:0]    term [PAD];
   logic [cmae_pkg::SUM_BITS-1:0]    lvl1 [PAD/2];
   logic [cmae_pkg::SUM_BITS-1:0]    lvl2 [PAD/4];
   logic [cmae_pkg::SUM_BITS-1:0]    sum_total;
   logic [cmae_pkg::SEEN_BITS-1:0]   lefts, nl, back_w;
   logic [cmae_pkg::DIV_BITS-1:0]    div_now;
   logic [cmae_pkg::SUM_BITS-1:0]    sum_ff;
   logic [cmae_pkg::DIV_BITS-1:0]    div_ff;
   logic [cmae_pkg::PROD_BITS-1:0]   prod_ff;
   logic                             nn_ff;
   logic                             nn2_ff;
   logic [cmae_pkg::SAMPLE_BITS-1:0] avg_ff;
   logic                             last_ff;
   logic                             nno_ff;
   logic                             valid_ff, valid_in;

   localparam logic [cmae_pkg::SEEN_BITS-1:0] HALF_S =
      cmae_pkg::SEEN_BITS'(cmae_pkg::HALF_WINDOW);

   always_comb begin
      back_w  = cmae_pkg::SEEN_BITS'(cmd.back);
      lefts   = cmd.avail - 1'b1 - back_w;
      nl      = (lefts > HALF_S) ? HALF_S : lefts;
      div_now = cmae_pkg::DIV_BITS'(nl + back_w);
      for (int j = 0; j < PAD; j++) begin
         term[j] = '0;
         if (j < cmae_pkg::WIN_DEPTH) begin
            if ((cmae_pkg::SEEN_BITS'(j) < back_w) ||
                ((cmae_pkg::SEEN_BITS'(j) > back_w) &&
                 (cmae_pkg::SEEN_BITS'(j) <= back_w + nl))) begin
               term[j] = cmae_pkg::SUM_BITS'(win_ff[j]);
            end
         end
      end
      for (int i = 0; i < PAD/2; i++) begin
         lvl1[i] = term[2*i] + term[2*i+1];
      end
      for (int i = 0; i < PAD/4; i++) begin
         lvl2[i] = lvl1[2*i] + lvl1[2*i+1];
      end
      sum_total = lvl2[0] + lvl2[1] + lvl2[2];
   end

   assign status.out_free = !valid_ff || out_ready;

   always_comb begin
      valid_in = valid_ff;
      if (cmd.load_out) begin
         valid_in = 1'b1;
      end else if (out_ready) begin
         valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.shift) begin
         win_ff[0] <= sample;
         for (int k = 1; k < cmae_pkg::WIN_DEPTH; k++) begin
            win_ff[k] <= win_ff[k-1];
         end
      end
      if (cmd.load_sum) begin
         sum_ff <= sum_total;
         div_ff <= div_now;
         nn_ff  <= (div_now == '0);
      end
      if (cmd.load_prod) begin
         prod_ff <= cmae_pkg::PROD_BITS'(sum_ff) *
                    cmae_pkg::PROD_BITS'(cmae_pkg::recip(div_ff));
         nn2_ff  <= nn_ff;
      end
      if (cmd.load_out) begin
         avg_ff  <= prod_ff[cmae_pkg::RECIP_SHIFT +: cmae_pkg::SAMPLE_BITS];
         last_ff <= cmd.last;
         nno_ff  <= nn2_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   assign average       = avg_ff;
   assign last_result   = last_ff;
   assign no_neighbours = nno_ff;
   assign out_valid     = valid_ff;

endmodule

[hdl/centered_moving_average_excl_center.sv]
// Result path: an accepted beat that yields a result is summed in SUM, multiplied in MUL and
// loaded in PUT, where rsp_tvalid rises; each further flushed result repeats SUM, MUL and PUT.
// A beat that yields a result holds off the next beat until that result is loaded; beats are
// accepted one per cycle while a frame has not yet filled half a window plus one. A frame-end
// beat holds the block until its pending results, up to 6, are loaded; output stalls hold PUT.
// Reset clears the controller, frame position and output valid; window contents are not cleared.
module centered_moving_average_excl_center (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [15:0] req_tdata,   // [15:0] sample
   input  logic        req_tlast,   // frame_end
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [15:0] rsp_tdata,   // [15:0] average
   output logic        rsp_tlast,   // last_result
   output logic [0:0]  rsp_tuser    // [0] no_neighbours
);

   cmae_pkg::cmd_type    cmd;
   cmae_pkg::status_type status;
   logic                 nn;

   cmae_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tlast  (req_tlast),
      .req_tready (req_tready),
      .status     (status),
      .cmd        (cmd)
   );

   cmae_dpath u_dpath (
      .clock         (clock),
      .reset         (reset),
      .sample        (req_tdata[cmae_pkg::SAMPLE_BITS-1:0]),
      .cmd           (cmd),
      .status        (status),
      .average       (rsp_tdata),
      .last_result   (rsp_tlast),
      .no_neighbours (nn),
      .out_valid     (rsp_tvalid),
      .out_ready     (rsp_tready)
   );

   assign rsp_tuser[0] = nn;

   a_nn_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tuser[0] |-> (rsp_tdata == '0) && rsp_tlast)
      else $error("single-sample result not zero or not last");

   a_load_free: assert property (@(posedge clock) disable iff (reset)
      cmd.load_out |-> status.out_free)
      else $error("result loaded over an untaken beat");

   a_ready_quiet: assert property (@(posedge clock) disable iff (reset)
      req_tready |-> !cmd.load_sum && !cmd.load_prod && !cmd.load_out)
      else $error("input ready while a result is in progress");

   a_reset_empty: assert property (@(posedge clock)
      reset |=> !rsp_tvalid)
      else $error("result valid after reset");

endmodule

[verif/centered_moving_average_excl_center_tb.sv]
// Self-checking testbench for the centred moving average that excludes the centre sample.
module centered_moving_average_excl_center_tb;

   localparam int ITEM_TARGET    = 360;
   localparam int LONG_HOLD      = 300;
   localparam int WATCHDOG_LIMIT = 2000;
   localparam int DRAIN_CYCLES   = 40;

   typedef enum {FILL_RANDOM, FILL_ZERO, FILL_MAX, FILL_ALTERNATE, FILL_EXTREME, FILL_SMALL}
      fill_kind_type;

   typedef struct packed {
      logic [15:0] average;
      logic        last_result;
      logic        no_neighbours;
   } mean_beat_type;

   class window_mean_scoreboard;
      logic [15:0]    window [cmae_pkg::WIN_DEPTH];
      int unsigned    seen;
      mean_beat_type  pending_means [$];
      int unsigned    errors;
      int unsigned    samples_in;
      int unsigned    means_out;
      int unsigned    frames;

      function new();
         foreach (window[i]) window[i] = '0;
         seen       = 0;
         errors     = 0;
         samples_in = 0;
         means_out  = 0;
         frames     = 0;
      endfunction

      function int unsigned pending();
         return pending_means.size();
      endfunction

      function void predict_mean(int unsigned back, bit last);
         int unsigned   nl;
         int unsigned   nr;
         logic [31:0]   sum;
         mean_beat_type m;
         nl = seen - 1 - back;
         nr = back;
         if (nl > cmae_pkg::HALF_WINDOW) nl = cmae_pkg::HALF_WINDOW;
         if (nr > cmae_pkg::HALF_WINDOW) nr = cmae_pkg::HALF_WINDOW;
         sum = '0;
         for (int k = 1; k <= nl; k++) sum += window[back + k];
         for (int k = 1; k <= nr; k++) sum += window[back - k];
         m.average       = (nl + nr != 0) ? 16'(sum / (nl + nr)) : 16'd0;
         m.last_result   = last;
         m.no_neighbours = (nl + nr == 0);
         pending_means.push_back(m);
      endfunction

      function void note_sample(logic [15:0] s, logic frame_end);
         int first;
         samples_in++;
         for (int k = cmae_pkg::WIN_DEPTH - 1; k > 0; k--) window[k] = window[k - 1];
         window[0] = s;
         if (seen < cmae_pkg::WIN_DEPTH) seen++;
         if (!frame_end) begin
            if (seen > cmae_pkg::HALF_WINDOW) predict_mean(cmae_pkg::HALF_WINDOW, 1'b0);
         end else begin
            first = seen - 1;
            if (first > cmae_pkg::HALF_WINDOW) first = cmae_pkg::HALF_WINDOW;
            for (int b = first; b >= 0; b--) predict_mean(b, b == 0);
            seen = 0;
            frames++;
         end
      endfunction

      function void check_mean(logic [15:0] average, logic last_result, logic no_neighbours);
         mean_beat_type m;
         means_out++;
         if (pending_means.size() == 0) begin
            $error("result beat with no expectation: average %0d", average);
            errors++;
            return;
         end
         m = pending_means.pop_front();
         if (average !== m.average) begin
            $error("average mismatch: expected %0d, actual %0d", m.average, average);
            errors++;
         end
         if (last_result !== m.last_result) begin
            $error("last_result mismatch: expected %0b, actual %0b", m.last_result, last_result);
            errors++;
         end
         if (no_neighbours !== m.no_neighbours) begin
            $error("no_neighbours mismatch: expected %0b, actual %0b",
                   m.no_neighbours, no_neighbours);
            errors++;
         end
      endfunction
   endclass

   logic        clock      = 1'b0;
   logic        reset      = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [15:0] req_tdata  = '0;
   logic        req_tlast  = 1'b0;
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [15:0] rsp_tdata;
   logic        rsp_tlast;
   logic [0:0]  rsp_tuser;

   window_mean_scoreboard sb;
   int unsigned burst_left    = 0;
   bit          steady        = 1'b0;
   int unsigned hold_requests = 0;
   int unsigned hold_seen     = 0;
   int unsigned hold_left     = 0;
   logic [7:0]  stall_phase   = '0;
   int unsigned idle_cycles   = 0;

   centered_moving_average_excl_center u_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tlast  (req_tlast),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast),
      .rsp_tuser  (rsp_tuser)
   );

   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   always @(posedge clock) begin
      if (!reset) begin
         if (req_tvalid && req_tready) sb.note_sample(req_tdata, req_tlast);
         if (rsp_tvalid && rsp_tready) sb.check_mean(rsp_tdata, rsp_tlast, rsp_tuser[0]);
      end
   end

   always @(posedge clock) begin
      if (hold_left != 0) begin
         rsp_tready <= 1'b0;
         hold_left  <= hold_left - 1;
      end else if (hold_seen != hold_requests) begin
         hold_seen  <= hold_requests;
         hold_left  <= LONG_HOLD;
         rsp_tready <= 1'b0;
      end else begin
         stall_phase <= stall_phase + 8'd1;
         case (stall_phase[7:6])
            2'd0: rsp_tready <= 1'b1;
            2'd1: rsp_tready <= 1'($urandom_range(0, 1));
            2'd2: rsp_tready <= ($urandom_range(0, 3) == 0);
            default: rsp_tready <= ($urandom_range(0, 9) != 0);
         endcase
      end
   end

   always @(posedge clock) begin
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)) begin
         idle_cycles <= 0;
      end else begin
         idle_cycles <= idle_cycles + 1;
         if (idle_cycles == WATCHDOG_LIMIT) begin
            $display("Simulation FAILED");
            $finish;
         end
      end
   end

   function automatic logic [15:0] sample_for(fill_kind_type kind, int idx);
      case (kind)
         FILL_ZERO:      return 16'h0000;
         FILL_MAX:       return 16'hFFFF;
         FILL_ALTERNATE: return idx[0] ? 16'h0000 : 16'hFFFF;
         FILL_EXTREME:   return $urandom_range(0, 1) ? 16'hFFFF : 16'h0000;
         FILL_SMALL:     return 16'($urandom_range(0, 15));
         default:        return 16'($urandom);
      endcase
   endfunction

   task automatic offer_sample(input logic [15:0] s, input logic frame_end);
      int unsigned gap;
      if (!steady && burst_left == 0) begin
         gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
         if (gap != 0) begin
            req_tvalid <= 1'b0;
            repeat (gap) @(posedge clock);
         end
         burst_left = $urandom_range(1, 16);
      end
      if (burst_left != 0) burst_left--;
      req_tvalid <= 1'b1;
      req_tdata  <= s;
      req_tlast  <= frame_end;
      do @(posedge clock); while (!req_tready);
   endtask

   task automatic send_frame(input int len, input fill_kind_type kind);
      for (int i = 0; i < len; i++) offer_sample(sample_for(kind, i), i == len - 1);
   endtask

   initial begin
      int            len;
      fill_kind_type kind;
      sb = new();
      repeat (7) @(posedge clock);
      reset <= 1'b0;

      send_frame(1, FILL_MAX);
      send_frame(1, FILL_ZERO);
      send_frame(2, FILL_ALTERNATE);
      send_frame(6, FILL_ALTERNATE);
      send_frame(12, FILL_MAX);
      send_frame(3, FILL_ZERO);

      hold_requests <= hold_requests + 1;
      steady = 1'b1;
      send_frame(40, FILL_RANDOM);
      steady = 1'b0;

      while (sb.samples_in < ITEM_TARGET) begin
         case ($urandom_range(0, 9))
            0, 1, 2, 3: len = $urandom_range(1, 6);
            4, 5, 6, 7: len = $urandom_range(7, 20);
            default:    len = $urandom_range(21, 40);
         endcase
         case ($urandom_range(0, 19))
            0, 1, 2:    kind = FILL_EXTREME;
            3, 4, 5:    kind = FILL_SMALL;
            default:    kind = FILL_RANDOM;
         endcase
         send_frame(len, kind);
      end
      req_tvalid <= 1'b0;
      @(posedge clock);

      while (sb.pending() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);

      $display("Covered %0d samples in %0d frames, %0d result beats checked,",
               sb.samples_in, sb.frames, sb.means_out);
      $display("including one-sample frames, full windows of extremes and a long output hold-off.");
      if (sb.errors == 0 && sb.pending() == 0) begin
         $display("Simulation PASSED");
      end else begin
         $display("Simulation FAILED");
      end
      $finish;
   end

endmodule
